/* hw/rtl/tppc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tppc_pkg: shared types and constants for the timer period calculator
// Holds the microcode program, opcode and jump-condition types, and the
// reciprocal constants used for the divide-by-constant steps.
// ----------------------------------------------------------------------------
package tppc_pkg;

   localparam int CLK_W    = 30;   // width of a clock frequency register
   localparam int PERIOD_W = 32;
   localparam int HALF_W   = 16;
   localparam int TPU_W    = 12;   // ticks per microsecond, up to 2147
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CLK_W-1:0] BUS_CLOCK_RESET  = 30'd84000000;
   localparam logic [CLK_W-1:0] CORE_CLOCK_RESET = 30'd84000000;

   localparam logic [CSR_IDX_W-1:0] CSR_BUS_CLOCK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_CLOCK = 2'd1;

   // x / 1000000 == (x * RECIP_1M) >> 50 for every x below 2^31
   localparam logic [31:0] RECIP_1M       = 32'd1125899907;
   localparam int          RECIP_1M_SHIFT = 50;
   // x / 10 == (x * RECIP_10) >> 35 for every 32-bit x
   localparam logic [31:0] RECIP_10       = 32'hCCCCCCCD;
   localparam int          RECIP_10_SHIFT = 35;

   localparam logic [31:0] DECIMAL_LIMIT = 32'h0FFFFFFF;
   localparam logic [15:0] PSC_ONE       = 16'd1;
   localparam logic [15:0] DECIMAL_TEN   = 16'd10;

   localparam logic [3:0] DIV_LAST = 4'd15;   // 16 quotient bits

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_CLK,
      OP_MULR,
      OP_TPU,
      OP_CNT,
      OP_PSCONE,
      OP_MUL10,
      OP_DIV10,
      OP_PSCDEC,
      OP_CLR,
      OP_DIVINIT,
      OP_DIVSTEP,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_PERIOD_ZERO,
      COND_FITS16,
      COND_BIG,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   // program labels
   localparam step_type STEP_WAIT    = 4'd0;
   localparam step_type STEP_CLK     = 4'd1;
   localparam step_type STEP_MULR    = 4'd2;
   localparam step_type STEP_TPU     = 4'd3;
   localparam step_type STEP_CNT     = 4'd4;
   localparam step_type STEP_FIT     = 4'd5;
   localparam step_type STEP_BIG     = 4'd6;
   localparam step_type STEP_PSCONE  = 4'd7;
   localparam step_type STEP_DECLOOP = 4'd8;
   localparam step_type STEP_MUL10   = 4'd9;
   localparam step_type STEP_DIV10   = 4'd10;
   localparam step_type STEP_DECEND  = 4'd11;
   localparam step_type STEP_ZERO    = 4'd12;
   localparam step_type STEP_LONG    = 4'd13;
   localparam step_type STEP_DIVSTEP = 4'd14;
   localparam step_type STEP_OUT     = 4'd15;

   // control store; a jump is taken when its condition holds,
   // otherwise the step counter advances (and wraps after OUT)
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      unique case (step)
         STEP_WAIT:    w = '{OP_LOAD,    COND_NO_REQ,      STEP_WAIT};
         STEP_CLK:     w = '{OP_CLK,     COND_PERIOD_ZERO, STEP_ZERO};
         STEP_MULR:    w = '{OP_MULR,    COND_NEVER,       STEP_WAIT};
         STEP_TPU:     w = '{OP_TPU,     COND_NEVER,       STEP_WAIT};
         STEP_CNT:     w = '{OP_CNT,     COND_NEVER,       STEP_WAIT};
         STEP_FIT:     w = '{OP_NOP,     COND_FITS16,      STEP_OUT};
         STEP_BIG:     w = '{OP_NOP,     COND_BIG,         STEP_LONG};
         STEP_PSCONE:  w = '{OP_PSCONE,  COND_NEVER,       STEP_WAIT};
         STEP_DECLOOP: w = '{OP_NOP,     COND_FITS16,      STEP_DECEND};
         STEP_MUL10:   w = '{OP_MUL10,   COND_NEVER,       STEP_WAIT};
         STEP_DIV10:   w = '{OP_DIV10,   COND_ALWAYS,      STEP_DECLOOP};
         STEP_DECEND:  w = '{OP_PSCDEC,  COND_ALWAYS,      STEP_OUT};
         STEP_ZERO:    w = '{OP_CLR,     COND_ALWAYS,      STEP_OUT};
         STEP_LONG:    w = '{OP_DIVINIT, COND_NEVER,       STEP_WAIT};
         STEP_DIVSTEP: w = '{OP_DIVSTEP, COND_DIV_MORE,    STEP_DIVSTEP};
         STEP_OUT:     w = '{OP_OUT,     COND_OUT_BUSY,    STEP_OUT};
         default:      w = '{OP_NOP,     COND_NEVER,       STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage : tppc_pkg
`default_nettype wire

/* hw/rtl/timer_period_prescaler_calc_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timer_period_prescaler_calc_top: period to prescaler/reload calculator
// Microcoded sequencer over a small datapath (one shared 32x32 multiplier,
// a one-bit-per-step restoring divider) turning a period in microseconds
// into timer prescaler, reload and enable values.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat carries req_period_us. req_stall is low only while
//   the sequencer sits at its wait step, one item is worked on at a time.
//   rsp_ channel: one beat per request with prescaler, reload and enable.
//   csr_ port: write bus clock (index 0) or core clock (index 1) in Hz while
//   the block is idle; other indexes are ignored.
// Paths through the microprogram: zero period, count fitting 16 bits,
//   decimal path with up to 4 divides by ten, and large count path
//   (16 steps of the divider). The next request is taken in the cycle after
//   the result is loaded into the output register.
// Reset: both clock registers return to 84 MHz, the sequencer goes to its
//   wait step and rsp_valid drops.
// Stall: a result waiting under rsp_stall is held in the output register;
//   the next item may be accepted and computed, and it waits at the output
//   step until the register frees up.
// ----------------------------------------------------------------------------
module timer_period_prescaler_calc_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [tppc_pkg::PERIOD_W-1:0]     req_period_us,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tppc_pkg::HALF_W-1:0]            rsp_prescaler,
   output logic [tppc_pkg::HALF_W-1:0]            rsp_reload,
   output logic                                   rsp_enable,
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [tppc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tppc_pkg::CLK_W-1:0]        csr_wdata
);

   // ---- control state ------------------------------------------------------
   tppc_pkg::step_type  step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          div_cnt_ff, div_cnt_in;
   logic [tppc_pkg::CLK_W-1:0] bus_clk_ff, bus_clk_in;
   logic [tppc_pkg::CLK_W-1:0] core_clk_ff, core_clk_in;

   // ---- datapath registers -------------------------------------------------
   logic [31:0]                 period_ff, period_in;
   logic [tppc_pkg::CLK_W:0]    tclk_ff, tclk_in;     // timer clock, 31 bits
   logic [63:0]                 prod_ff, prod_in;
   logic [tppc_pkg::TPU_W-1:0]  tpu_ff, tpu_in;       // ticks per microsecond
   logic [31:0]                 count_ff, count_in;
   logic [15:0]                 psc_ff, psc_in;
   logic [15:0]                 rem_ff, rem_in;
   logic [15:0]                 out_psc_ff, out_psc_in;
   logic [15:0]                 out_rld_ff, out_rld_in;
   logic                        out_en_ff, out_en_in;

   // ---- decode -------------------------------------------------------------
   tppc_pkg::ucode_type uword;
   logic                req_beat;
   logic                out_busy;
   logic                jump;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // divider step
   logic [16:0] div_d;
   logic [16:0] div_shift;
   logic [16:0] div_diff;
   logic        div_ge;

   logic [31:0] count_m1;

   assign uword    = tppc_pkg::ucode_rom(step_ff);
   assign req_stall = (step_ff != tppc_pkg::STEP_WAIT);
   assign req_beat = req_valid && !req_stall;
   assign out_busy = rsp_valid_ff && rsp_stall;

   assign mul_p = mul_a * mul_b;

   // restoring division: remainder always below divisor, so 16 bits hold it
   assign div_d     = {1'b0, psc_ff} + 17'd1;
   assign div_shift = {rem_ff, count_ff[15]};
   assign div_diff  = div_shift - div_d;
   assign div_ge    = (div_shift >= div_d);

   assign count_m1 = count_ff - 32'd1;

   // ---- sequencer: jump condition and next step ----------------------------
   always_comb begin
      unique case (uword.cond)
         tppc_pkg::COND_NEVER:       jump = 1'b0;
         tppc_pkg::COND_ALWAYS:      jump = 1'b1;
         tppc_pkg::COND_NO_REQ:      jump = !req_valid;
         tppc_pkg::COND_PERIOD_ZERO: jump = (period_ff == 32'd0);
         tppc_pkg::COND_FITS16:      jump = (count_ff[31:16] == 16'd0);
         tppc_pkg::COND_BIG:         jump = (count_ff >= tppc_pkg::DECIMAL_LIMIT);
         tppc_pkg::COND_DIV_MORE:    jump = (div_cnt_ff != tppc_pkg::DIV_LAST);
         tppc_pkg::COND_OUT_BUSY:    jump = out_busy;
         default:                    jump = 1'b0;
      endcase
      step_in = jump ? uword.target : step_ff + 1'b1;
   end

   // ---- control word drives the datapath -----------------------------------
   always_comb begin
      period_in    = period_ff;
      tclk_in      = tclk_ff;
      prod_in      = prod_ff;
      tpu_in       = tpu_ff;
      count_in     = count_ff;
      psc_in       = psc_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      out_psc_in   = out_psc_ff;
      out_rld_in   = out_rld_ff;
      out_en_in    = out_en_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = count_ff;
      mul_b        = tppc_pkg::RECIP_10;

      unique case (uword.op)
         tppc_pkg::OP_NOP: begin
         end
         tppc_pkg::OP_LOAD: begin
            if (req_beat) begin
               period_in = req_period_us;
            end
         end
         tppc_pkg::OP_CLK: begin
            // doubled when bus and core clocks differ
            tclk_in = (bus_clk_ff != core_clk_ff) ? {bus_clk_ff, 1'b0}
                                                  : {1'b0, bus_clk_ff};
         end
         tppc_pkg::OP_MULR: begin
            mul_a   = {1'b0, tclk_ff};
            mul_b   = tppc_pkg::RECIP_1M;
            prod_in = mul_p;
         end
         tppc_pkg::OP_TPU: begin
            tpu_in = prod_ff[tppc_pkg::RECIP_1M_SHIFT +: tppc_pkg::TPU_W];
         end
         tppc_pkg::OP_CNT: begin
            // tick count, kept modulo 2^32
            mul_a    = {{(32 - tppc_pkg::TPU_W){1'b0}}, tpu_ff};
            mul_b    = period_ff;
            count_in = mul_p[31:0];
            psc_in   = 16'd0;
         end
         tppc_pkg::OP_PSCONE: begin
            psc_in = tppc_pkg::PSC_ONE;
         end
         tppc_pkg::OP_MUL10: begin
            mul_a   = count_ff;
            mul_b   = tppc_pkg::RECIP_10;
            prod_in = mul_p;
            psc_in  = 16'(psc_ff * tppc_pkg::DECIMAL_TEN);
         end
         tppc_pkg::OP_DIV10: begin
            count_in = {3'd0, prod_ff[63:tppc_pkg::RECIP_10_SHIFT]};
         end
         tppc_pkg::OP_PSCDEC: begin
            psc_in = psc_ff - 16'd1;
         end
         tppc_pkg::OP_CLR: begin
            psc_in   = 16'd0;
            count_in = 32'd0;
         end
         tppc_pkg::OP_DIVINIT: begin
            // prescaler is the high half; it also seeds the remainder
            psc_in     = count_ff[31:16];
            rem_in     = count_ff[31:16];
            count_in   = {16'd0, count_ff[15:0]};
            div_cnt_in = 4'd0;
         end
         tppc_pkg::OP_DIVSTEP: begin
            rem_in     = div_ge ? div_diff[15:0] : div_shift[15:0];
            count_in   = {16'd0, count_ff[14:0], div_ge};
            div_cnt_in = div_cnt_ff + 4'd1;
         end
         tppc_pkg::OP_OUT: begin
            if (!out_busy) begin
               out_psc_in   = psc_ff;
               out_rld_in   = (count_ff == 32'd0) ? 16'd0 : count_m1[15:0];
               out_en_in    = (period_ff != 32'd0);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---- configuration writes -----------------------------------------------
   always_comb begin
      bus_clk_in  = bus_clk_ff;
      core_clk_in = core_clk_ff;
      if (csr_we && (csr_index == tppc_pkg::CSR_BUS_CLOCK)) begin
         bus_clk_in = csr_wdata;
      end
      if (csr_we && (csr_index == tppc_pkg::CSR_CORE_CLOCK)) begin
         core_clk_in = csr_wdata;
      end
   end

   // ---- registers ----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= tppc_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= 4'd0;
         bus_clk_ff   <= tppc_pkg::BUS_CLOCK_RESET;
         core_clk_ff  <= tppc_pkg::CORE_CLOCK_RESET;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
         bus_clk_ff   <= bus_clk_in;
         core_clk_ff  <= core_clk_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff  <= period_in;
      tclk_ff    <= tclk_in;
      prod_ff    <= prod_in;
      tpu_ff     <= tpu_in;
      count_ff   <= count_in;
      psc_ff     <= psc_in;
      rem_ff     <= rem_in;
      out_psc_ff <= out_psc_in;
      out_rld_ff <= out_rld_in;
      out_en_ff  <= out_en_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prescaler = out_psc_ff;
   assign rsp_reload    = out_rld_ff;
   assign rsp_enable    = out_en_ff;

   // ---- assertions ---------------------------------------------------------
   // a request beat always moves the sequencer off the wait step
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("request taken but sequencer stayed at wait step");

   // divider remainder stays below the divisor on every step
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (uword.op == tppc_pkg::OP_DIVSTEP) |-> ({1'b0, rem_ff} < div_d))
      else $error("divider remainder out of range");

   // decimal path reaches its decrement step with a power of ten in the prescaler
   a_dec_psc: assert property (@(posedge clock) disable iff (reset)
      (uword.op == tppc_pkg::OP_PSCDEC) |->
         (psc_ff == 16'd1 || psc_ff == 16'd10 || psc_ff == 16'd100 ||
          psc_ff == 16'd1000 || psc_ff == 16'd10000))
      else $error("decimal prescaler not a power of ten");

   // the final count fits the reload register when the result is loaded
   a_count_fits: assert property (@(posedge clock) disable iff (reset)
      (uword.op == tppc_pkg::OP_OUT && !out_busy) |-> (count_ff[31:16] == 16'd0))
      else $error("final count exceeds 16 bits");

endmodule : timer_period_prescaler_calc_top
`default_nettype wire
